@@ rtl/wstq_pkg.sv @@
// wstq_pkg: shared types, codes and constants for the work stealing task queues
// used by wstq_ctrl, wstq_dp and work_stealing_task_queues; no dependencies
package wstq_pkg;

    // default configuration of the queue array
    localparam int WORKERS_DEF = 8;
    localparam int DEPTH_DEF   = 1024;

    // fixed field widths
    localparam int MODE_W    = 2;
    localparam int HANDLE_W  = 32;
    localparam int WID_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int PENDING_W = 14;

    // victim mixing and seed
    localparam logic [31:0] MIX_MASK   = 32'hDEAD_BEEF;
    localparam logic [31:0] SEED_RESET = 32'h1234_5678;
    localparam logic [PENDING_W-1:0] PENDING_MAX = 14'd16383;

    // modulo unit: reciprocal multiply, then multiply-subtract, as separate steps
    localparam int MOD_STEPS = 2;
    localparam int MSTEP_W   = $clog2(MOD_STEPS);

    // item modes
    localparam logic [MODE_W-1:0] MODE_SUBMIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FETCH    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GIVEN     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COUNTED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic item_load;
        logic exec;
        logic mod_step;
        logic steal;
        logic out_load;
    } wstq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_victim;
        logic mod_last;
        logic steal_ok;
        logic out_free;
    } wstq_sts_t;

    // three-stage xorshift of the masked victim counter
    function automatic logic [31:0] wstq_mix(input logic [31:0] ctr);
        logic [31:0] x;
        x = ctr ^ MIX_MASK;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

@@ rtl/work_stealing_task_queues.sv @@
// work_stealing_task_queues: per-worker ring deques with round-robin submit and stealing
// submit, complete and own pop pass the exec and response states; a fetch that picks
// a victim also passes the modulo and steal states (xorshift, reciprocal modulo, steal).
// one item at a time; a new one is taken after the result loads, which waits on m_ready
// reset: synchronous active low; clears counts, tops, pointers, pending, victim counter
// to 0x12345678; the task store is not cleared and needs no clearing pass
module work_stealing_task_queues #(
    parameter int WORKERS = wstq_pkg::WORKERS_DEF,
    parameter int DEPTH   = wstq_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [31:0]                         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wstq_pkg::MODE_W-1:0]         s_mode,
    input  logic [wstq_pkg::HANDLE_W-1:0]       s_task_handle,
    input  logic [wstq_pkg::WID_W-1:0]          s_worker_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wstq_pkg::STATUS_W-1:0]       m_status,
    output logic [wstq_pkg::HANDLE_W-1:0]       m_task_handle_out,
    output logic                                m_from_peer,
    output logic [wstq_pkg::WID_W-1:0]          m_deque_id,
    output logic [wstq_pkg::PENDING_W-1:0]      m_pending_count,
    output logic                                m_all_done
);
    import wstq_pkg::*;

    wstq_cmd_t cmd;
    wstq_sts_t sts;

    // sequencing
    wstq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // deques, store and result register
    wstq_dp #(
        .WORKERS (WORKERS),
        .DEPTH   (DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_mode            (s_mode),
        .s_task_handle     (s_task_handle),
        .s_worker_id       (s_worker_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_task_handle_out (m_task_handle_out),
        .m_from_peer       (m_from_peer),
        .m_deque_id        (m_deque_id),
        .m_pending_count   (m_pending_count),
        .m_all_done        (m_all_done)
    );

endmodule

@@ rtl/wstq_ctrl.sv @@
// wstq_ctrl: sequencing state machine of the work stealing task queues
// depends on wstq_pkg for the command and status structs
module wstq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wstq_pkg::wstq_sts_t sts,
    output wstq_pkg::wstq_cmd_t cmd
);
    import wstq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_STEAL,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = sts.need_victim ? ST_MOD : ST_RESP;
            end
            ST_MOD: begin
                if (sts.mod_last) begin
                    state_next = ST_STEAL;
                end
            end
            ST_STEAL: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands decoded from state
    assign s_ready       = (state_reg == ST_IDLE);
    assign cmd.item_load = (state_reg == ST_IDLE) && s_valid;
    assign cmd.exec      = (state_reg == ST_EXEC);
    assign cmd.mod_step  = (state_reg == ST_MOD);
    assign cmd.steal     = (state_reg == ST_STEAL);
    assign cmd.out_load  = (state_reg == ST_RESP) && sts.out_free;

endmodule

@@ rtl/wstq_dp.sv @@
// wstq_dp: deque bookkeeping, task store, victim modulo unit and result register
// depends on wstq_pkg; driven by commands from wstq_ctrl
module wstq_dp #(
    parameter int WORKERS = wstq_pkg::WORKERS_DEF,
    parameter int DEPTH   = wstq_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wstq_pkg::wstq_cmd_t                 cmd,
    output wstq_pkg::wstq_sts_t                 sts,
    input  logic                                cfg_we,
    input  logic [31:0]                         cfg_wdata,
    input  logic [wstq_pkg::MODE_W-1:0]         s_mode,
    input  logic [wstq_pkg::HANDLE_W-1:0]       s_task_handle,
    input  logic [wstq_pkg::WID_W-1:0]          s_worker_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wstq_pkg::STATUS_W-1:0]       m_status,
    output logic [wstq_pkg::HANDLE_W-1:0]       m_task_handle_out,
    output logic                                m_from_peer,
    output logic [wstq_pkg::WID_W-1:0]          m_deque_id,
    output logic [wstq_pkg::PENDING_W-1:0]      m_pending_count,
    output logic                                m_all_done
);
    import wstq_pkg::*;

    localparam int IW    = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int TW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(WORKERS * DEPTH);
    localparam int RW    = $clog2(WORKERS + 1) + 1;
    localparam int SLOTS = WORKERS * DEPTH;
    localparam int LW    = $clog2(WORKERS);
    localparam logic [32:0] MOD_RECIP =
        33'(((64'd1 << (32 + LW)) / 64'(WORKERS)) + 64'd1);

    // (a + b) folded into the ring
    function automatic logic [TW-1:0] ring_add(input logic [TW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return TW'(s);
    endfunction

    // flat store address of a deque slot
    function automatic logic [AW-1:0] slot_addr(input logic [IW-1:0] d, input logic [TW-1:0] slot);
        return AW'(32'(d) * 32'(DEPTH) + 32'(slot));
    endfunction

    // item registers
    logic [MODE_W-1:0]   mode_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [WID_W-1:0]    wid_reg;

    // deque state
    logic [TW-1:0] top_reg [WORKERS];
    logic [CW-1:0] cnt_reg [WORKERS];
    logic [IW-1:0] sp_reg, sp_next;
    logic [31:0]   vc_reg, vc_next;
    logic [PENDING_W-1:0] pend_reg, pend_next;

    // victim modulo unit
    logic [31:0]      x_reg, x_next;
    logic [31:0]      q_reg, q_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [MSTEP_W-1:0] mstep_reg, mstep_next;
    logic [64:0]      mod_prod;
    logic [31:0]      mod_quo;
    logic [RW-1:0]    mod_rem;

    // pending result fields
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_peer_reg, res_peer_next;
    logic [IW-1:0]       res_did_reg, res_did_next;
    logic                res_done_reg, res_done_next;

    // task store
    logic [HANDLE_W-1:0] mem [SLOTS];
    logic [HANDLE_W-1:0] rd_data_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_addr;

    // deque array access, one index per cycle
    logic          wid_ok;
    logic [IW-1:0] wid_idx, victim, sel_idx;
    logic [TW-1:0] sel_top, top_next;
    logic [CW-1:0] sel_cnt, cnt_dec, cnt_next;
    logic          top_we, cnt_we;
    logic          full;

    // output register
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [HANDLE_W-1:0]  m_handle_reg;
    logic                 m_peer_reg;
    logic [WID_W-1:0]     m_did_reg;
    logic [PENDING_W-1:0] m_pend_reg;
    logic                 m_done_reg;

    // index selection
    assign wid_ok  = (32'(wid_reg) < 32'(WORKERS));
    assign wid_idx = wid_ok ? IW'(wid_reg) : '0;
    assign victim  = IW'(rem_reg);
    assign sel_idx = cmd.steal ? victim : ((mode_reg == MODE_SUBMIT) ? sp_reg : wid_idx);
    assign sel_top = top_reg[sel_idx];
    assign sel_cnt = cnt_reg[sel_idx];
    assign cnt_dec = sel_cnt - CW'(1);
    assign full    = (sel_cnt == CW'(DEPTH)) || (pend_reg == PENDING_MAX);

    // victim remainder: quotient by reciprocal multiply, then subtract
    assign mod_prod = 65'(x_reg) * 65'(MOD_RECIP);
    assign mod_quo  = 32'(mod_prod >> (32 + LW));
    assign mod_rem  = RW'(x_reg - q_reg * 32'(WORKERS));

    // status to controller
    assign sts.need_victim = (mode_reg == MODE_FETCH) && wid_ok && (sel_cnt == '0);
    assign sts.mod_last    = (mstep_reg == MSTEP_W'(MOD_STEPS - 1));
    assign sts.steal_ok    = (32'(victim) != 32'(wid_reg)) && (sel_cnt != '0);
    assign sts.out_free    = !m_valid_reg || m_ready;

    // item execution
    always_comb begin
        sp_next         = sp_reg;
        vc_next         = vc_reg;
        pend_next       = pend_reg;
        x_next          = x_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        mstep_next      = mstep_reg;
        res_status_next = res_status_reg;
        res_peer_next   = res_peer_reg;
        res_did_next    = res_did_reg;
        res_done_next   = res_done_reg;
        top_we          = 1'b0;
        top_next        = sel_top;
        cnt_we          = 1'b0;
        cnt_next        = sel_cnt;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = slot_addr(sel_idx, sel_top);

        if (cmd.exec) begin
            res_status_next = ST_NONE;
            res_peer_next   = 1'b0;
            res_did_next    = '0;
            res_done_next   = 1'b0;
            case (mode_reg)
                MODE_SUBMIT: begin
                    sp_next      = (sp_reg == IW'(WORKERS - 1)) ? '0 : sp_reg + IW'(1);
                    res_did_next = sp_reg;
                    if (full) begin
                        res_status_next = ST_REJECTED;
                    end else begin
                        mem_we          = 1'b1;
                        mem_addr        = slot_addr(sp_reg, ring_add(sel_top, sel_cnt));
                        cnt_we          = 1'b1;
                        cnt_next        = sel_cnt + CW'(1);
                        pend_next       = pend_reg + PENDING_W'(1);
                        res_status_next = ST_ACCEPTED;
                    end
                end
                MODE_FETCH: begin
                    if (wid_ok && (sel_cnt != '0)) begin
                        // pop own bottom
                        cnt_we          = 1'b1;
                        cnt_next        = cnt_dec;
                        mem_re          = 1'b1;
                        mem_addr        = slot_addr(wid_idx, ring_add(sel_top, cnt_dec));
                        res_status_next = ST_GIVEN;
                        res_did_next    = wid_idx;
                    end else if (wid_ok) begin
                        // own deque empty: start victim selection
                        x_next     = wstq_mix(vc_reg);
                        vc_next    = vc_reg + 32'd1;
                        mstep_next = '0;
                    end
                end
                MODE_COMPLETE: begin
                    if (pend_reg == '0) begin
                        res_status_next = ST_UNDERFLOW;
                    end else begin
                        pend_next       = pend_reg - PENDING_W'(1);
                        res_status_next = ST_COUNTED;
                        res_done_next   = (pend_reg == PENDING_W'(1));
                    end
                end
                default: begin
                    res_status_next = ST_NONE;
                end
            endcase
        end

        // quotient first, remainder on the last step
        if (cmd.mod_step) begin
            mstep_next = mstep_reg + MSTEP_W'(1);
            if (sts.mod_last) begin
                rem_next = mod_rem;
            end else begin
                q_next = mod_quo;
            end
        end

        // steal victim's top
        if (cmd.steal && sts.steal_ok) begin
            mem_re          = 1'b1;
            mem_addr        = slot_addr(victim, sel_top);
            top_we          = 1'b1;
            top_next        = ring_add(sel_top, CW'(1));
            cnt_we          = 1'b1;
            cnt_next        = cnt_dec;
            res_status_next = ST_GIVEN;
            res_peer_next   = 1'b1;
            res_did_next    = victim;
        end

        if (cfg_we) begin
            vc_next = cfg_wdata;
        end
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORKERS; i++) begin
                top_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            sp_reg      <= '0;
            vc_reg      <= SEED_RESET;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (top_we) begin
                top_reg[sel_idx] <= top_next;
            end
            if (cnt_we) begin
                cnt_reg[sel_idx] <= cnt_next;
            end
            sp_reg   <= sp_next;
            vc_reg   <= vc_next;
            pend_reg <= pend_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            mode_reg   <= s_mode;
            handle_reg <= s_task_handle;
            wid_reg    <= s_worker_id;
        end
        x_reg          <= x_next;
        q_reg          <= q_next;
        rem_reg        <= rem_next;
        mstep_reg      <= mstep_next;
        res_status_reg <= res_status_next;
        res_peer_reg   <= res_peer_next;
        res_did_reg    <= res_did_next;
        res_done_reg   <= res_done_next;
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_handle_reg <= (res_status_reg == ST_GIVEN) ? rd_data_reg : '0;
            m_peer_reg   <= res_peer_reg;
            m_did_reg    <= WID_W'(res_did_reg);
            m_pend_reg   <= pend_reg;
            m_done_reg   <= res_done_reg;
        end
    end

    // task store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= handle_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_task_handle_out = m_handle_reg;
    assign m_from_peer       = m_peer_reg;
    assign m_deque_id        = m_did_reg;
    assign m_pending_count   = m_pend_reg;
    assign m_all_done        = m_done_reg;

`ifndef SYNTHESIS
    // a new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

    // a counted completion lowers pending by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (mode_reg == MODE_COMPLETE) && (pend_reg != '0))
        |=> (pend_reg == PENDING_W'($past(pend_reg) - PENDING_W'(1))))
        else $error("pending count not decremented on completion");

    // a steal only follows the last modulo step
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.steal |-> $past(cmd.mod_step))
        else $error("steal issued before victim was ready");

    // no handle or peer flag leaves without a task
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_GIVEN)) |-> ((m_task_handle_out == '0) && !m_from_peer))
        else $error("handle or peer flag set without a task");
`endif

endmodule

@@ tb/sv/tb_work_stealing_task_queues.sv @@
// tb_work_stealing_task_queues: self-checking testbench for the work stealing task queues
// keeps its own copy of the deques, round-robin pointer, victim counter and pending count
// depends on wstq_pkg and work_stealing_task_queues
module tb_work_stealing_task_queues;
    timeunit 1ns;
    timeprecision 1ps;

    import wstq_pkg::*;

    localparam int WORKERS = WORKERS_DEF;
    localparam int DEPTH   = DEPTH_DEF;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // one result item as the block reports it
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [HANDLE_W-1:0]  handle;
        logic                 from_peer;
        logic [WID_W-1:0]     deque_id;
        logic [PENDING_W-1:0] pending;
        logic                 all_done;
    } reply_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [31:0]          cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode        = MODE_SUBMIT;
    logic [HANDLE_W-1:0]  s_task_handle = '0;
    logic [WID_W-1:0]     s_worker_id   = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [HANDLE_W-1:0]  m_task_handle_out;
    logic                 m_from_peer;
    logic [WID_W-1:0]     m_deque_id;
    logic [PENDING_W-1:0] m_pending_count;
    logic                 m_all_done;

    // shadow state of the dispatcher
    logic [31:0] dq_slots [WORKERS][DEPTH];
    int          dq_top   [WORKERS];
    int          dq_count [WORKERS];
    int          rr_ptr;
    logic [31:0] steal_ctr;
    int          tasks_open;

    reply_t dispatch_replies [$];

    // run control and bookkeeping
    bit quiet = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int replies_seen = 0;
    int n_items = 0, n_pops = 0, n_steals = 0, n_full = 0, n_underflow = 0, n_done = 0;
    int n_seeds = 1;

    work_stealing_task_queues #(
        .WORKERS(WORKERS),
        .DEPTH  (DEPTH)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_task_handle    (s_task_handle),
        .s_worker_id      (s_worker_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_task_handle_out(m_task_handle_out),
        .m_from_peer      (m_from_peer),
        .m_deque_id       (m_deque_id),
        .m_pending_count  (m_pending_count),
        .m_all_done       (m_all_done)
    );

    always #1 aclk = ~aclk;

    // work out the result of one item and advance the shadow state
    function automatic reply_t work_dispatch(input logic [MODE_W-1:0] mode,
                                             input logic [HANDLE_W-1:0] handle,
                                             input logic [WID_W-1:0] wid);
        reply_t r;
        int d, v, slot;
        logic [31:0] x;
        r = '0;
        r.status = ST_NONE;
        case (mode)
            MODE_SUBMIT: begin
                d = rr_ptr;
                rr_ptr = (d + 1) % WORKERS;
                r.deque_id = WID_W'(d);
                if (dq_count[d] >= DEPTH || tasks_open >= PENDING_MAX) begin
                    r.status = ST_REJECTED;
                end else begin
                    slot = (dq_top[d] + dq_count[d]) % DEPTH;
                    dq_slots[d][slot] = handle;
                    dq_count[d]++;
                    tasks_open++;
                    r.status = ST_ACCEPTED;
                end
            end
            MODE_FETCH: begin
                if (int'(wid) < WORKERS) begin
                    if (dq_count[wid] > 0) begin
                        // own deque, newest entry
                        dq_count[wid]--;
                        slot = (dq_top[wid] + dq_count[wid]) % DEPTH;
                        r.handle = dq_slots[wid][slot];
                        r.deque_id = wid;
                        r.status = ST_GIVEN;
                    end else begin
                        // xorshift the counter to pick a victim, take its oldest entry
                        x = steal_ctr ^ MIX_MASK;
                        steal_ctr = steal_ctr + 32'd1;
                        x = x ^ (x << 13);
                        x = x ^ (x >> 17);
                        x = x ^ (x << 5);
                        v = x % WORKERS;
                        if (v != int'(wid) && dq_count[v] > 0) begin
                            slot = dq_top[v];
                            r.handle = dq_slots[v][slot];
                            dq_top[v] = (slot + 1) % DEPTH;
                            dq_count[v]--;
                            r.from_peer = 1'b1;
                            r.deque_id = WID_W'(v);
                            r.status = ST_GIVEN;
                        end
                    end
                end
            end
            MODE_COMPLETE: begin
                if (tasks_open == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    tasks_open--;
                    r.status = ST_COUNTED;
                    r.all_done = (tasks_open == 0);
                end
            end
            default: ;
        endcase
        r.pending = tasks_open[PENDING_W-1:0];
        return r;
    endfunction

    // random handle with the extremes mixed in
    function automatic logic [31:0] rand_handle();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch at result %0d: %s", $time, replies_seen, what);
    endtask

    // offer one item, hold it until taken, then maybe idle a while
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                             input logic [WID_W-1:0] wid);
        reply_t r;
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_task_handle <= handle;
        s_worker_id   <= wid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = work_dispatch(mode, handle, wid);
        dispatch_replies.push_back(r);
        n_items++;
        case (r.status)
            ST_GIVEN:     if (r.from_peer) n_steals++; else n_pops++;
            ST_REJECTED:  n_full++;
            ST_UNDERFLOW: n_underflow++;
            default: ;
        endcase
        if (r.all_done) n_done++;
        if (!quiet) begin
            while ($urandom_range(99) < 37) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        int spins;
        s_valid <= 1'b0;
        spins = 0;
        while (dispatch_replies.size() != 0 && spins < 20000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        steal_ctr = seed;
        n_seeds++;
    endtask

    // receiver: check each result, then pick ready for the next cycle
    always @(posedge aclk) begin : rx
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (dispatch_replies.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = dispatch_replies.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                if (m_task_handle_out !== want.handle)
                    report_mismatch($sformatf("handle %h, want %h",
                                              m_task_handle_out, want.handle));
                if (m_from_peer !== want.from_peer)
                    report_mismatch($sformatf("from_peer %b, want %b",
                                              m_from_peer, want.from_peer));
                if (m_deque_id !== want.deque_id)
                    report_mismatch($sformatf("deque %0d, want %0d", m_deque_id, want.deque_id));
                if (m_pending_count !== want.pending)
                    report_mismatch($sformatf("pending %0d, want %0d",
                                              m_pending_count, want.pending));
                if (m_all_done !== want.all_done)
                    report_mismatch($sformatf("all_done %b, want %b", m_all_done, want.all_done));
            end
            replies_seen++;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 37);
        end
    end

    // corner cases straight after reset with the reset seed
    task automatic test_directed();
        logic [31:0] probe [9];
        int i;
        probe = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hA5A5_A5A5,
                  32'h5A5A_5A5A, 32'h0000_0001, 32'hFFFF_FFFE, 32'h1357_9BDF};
        // completion with nothing pending, fetch with all deques empty, unused mode
        send_item(MODE_COMPLETE, 32'h0000_0000, 3'd0);
        send_item(MODE_FETCH, 32'hFFFF_FFFF, 3'd0);
        send_item(MODE_SPARE, 32'hFFFF_FFFF, 3'd7);
        // round-robin submits, deque 0 gets two entries
        for (i = 0; i < 9; i++) send_item(MODE_SUBMIT, probe[i], 3'(i));
        // own pops newest first, then an empty own deque forces a steal attempt
        repeat (3) send_item(MODE_FETCH, 32'h0000_0000, 3'd0);
        send_item(MODE_FETCH, 32'h0000_0000, 3'd7);
        send_item(MODE_FETCH, 32'hFFFF_FFFF, 3'd7);
        send_item(MODE_FETCH, 32'h0000_0000, 3'd3);
        // count completions down to zero
        while (tasks_open > 0) send_item(MODE_COMPLETE, rand_handle(), 3'($urandom));
    endtask

    // victim counter from several seeds, the extremes among them
    task automatic test_seed_sweep();
        logic [31:0] seeds [4];
        int s;
        seeds = '{32'h0000_0000, 32'hFFFF_FFFF, SEED_RESET, $urandom};
        for (s = 0; s < 4; s++) begin
            settle();
            load_seed(seeds[s]);
            repeat (16) send_item(MODE_SUBMIT, rand_handle(), 3'($urandom));
            repeat (24) send_item(MODE_FETCH, rand_handle(), 3'($urandom));
            while (tasks_open > 0) send_item(MODE_COMPLETE, rand_handle(), 3'($urandom));
        end
    endtask

    // submit / fetch / complete rounds with random content, plus stray items
    task automatic test_random_traffic();
        int counted, k, n;
        counted = 0;
        while (counted < 870) begin
            quiet = (counted >= 400 && counted < 600);
            if ($urandom_range(99) < 80) begin
                k = $urandom_range(1, 12);
                repeat (k) send_item(MODE_SUBMIT, rand_handle(), 3'($urandom));
                n = k + int'($urandom_range(0, 3));
                repeat (n) send_item(MODE_FETCH, rand_handle(), 3'($urandom));
                counted += k + n;
                n = k + int'($urandom_range(0, 2)) - int'($urandom_range(0, 2));
                if (n < 0) n = 0;
                repeat (n) send_item(MODE_COMPLETE, rand_handle(), 3'($urandom));
                counted += n;
            end else begin
                k = $urandom_range(3);
                send_item(MODE_W'(k), rand_handle(), 3'($urandom));
                if (k != MODE_SPARE) counted++;
            end
        end
        quiet = 1'b0;
    endtask

    // results held back for a long stretch while items keep coming
    task automatic test_output_backpressure();
        int i;
        settle();
        hold_left = 250;
        for (i = 0; i < 48; i++)
            send_item((i % 3 == 2) ? MODE_FETCH : MODE_SUBMIT, rand_handle(), 3'($urandom));
        while (tasks_open > 0) send_item(MODE_COMPLETE, rand_handle(), 3'($urandom));
    endtask

    // test sequence
    initial begin
        int w;
        for (w = 0; w < WORKERS; w++) begin
            dq_top[w] = 0;
            dq_count[w] = 0;
        end
        rr_ptr = 0;
        steal_ctr = SEED_RESET;
        tasks_open = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_seed_sweep();
        test_random_traffic();
        test_output_backpressure();

        settle();
        if (dispatch_replies.size() != 0)
            report_mismatch($sformatf("%0d results never came", dispatch_replies.size()));
        $display("covered %0d items, %0d results checked, %0d victim seeds",
                 n_items, replies_seen, n_seeds);
        $display("%0d own pops, %0d steals, %0d rejected submits, %0d underflows, %0d all done",
                 n_pops, n_steals, n_full, n_underflow, n_done);
        if (mismatches == 0) begin
            $display("[work_stealing_task_queues] OK");
        end else begin
            $display("[work_stealing_task_queues] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[work_stealing_task_queues] ERROR");
        $finish;
    end

endmodule
